@@ rtl/ppp_pkg.sv @@
package ppp_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SCALE_W       = 32;
  localparam int DIM_W         = 13;
  localparam int OUT_W         = 16;
  localparam int DEPTH_SHIFT   = OUT_W - 1;
  // quotient bits kept; anything at or above 2^(FRAC_BITS+QUO_GUARD) saturates that lane's output
  localparam int QUO_GUARD     = 17;
  localparam int LANES         = 3;

  localparam logic signed [SCALE_W-1:0] X_SCALE_RST  = SCALE_W'(1 << FRAC_BITS_DEF);
  localparam logic signed [SCALE_W-1:0] Y_SCALE_RST  = SCALE_W'(1 << FRAC_BITS_DEF);
  localparam logic signed [SCALE_W-1:0] Z_SCALE_RST  = -SCALE_W'(1 << FRAC_BITS_DEF);
  localparam logic signed [SCALE_W-1:0] Z_OFFSET_RST = '0;
  localparam logic [DIM_W-1:0]          WIDTH_RST    = DIM_W'(640);
  localparam logic [DIM_W-1:0]          HEIGHT_RST   = DIM_W'(480);

  typedef enum logic [2:0] {
    REG_X_SCALE       = 3'd0,
    REG_Y_SCALE       = 3'd1,
    REG_Z_SCALE       = 3'd2,
    REG_Z_OFFSET      = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0] x_scale;
    logic signed [SCALE_W-1:0] y_scale;
    logic signed [SCALE_W-1:0] z_scale;
    logic signed [SCALE_W-1:0] z_offset;
    logic [DIM_W-1:0]          screen_width;
    logic [DIM_W-1:0]          screen_height;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;
    logic [OUT_W-1:0]        depth;
    logic                    behind_camera;
    logic                    saturated;
  } result_t;

  // side flags that ride along with the three lanes
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic [LANES-1:0] ovf;
    logic             behind;
  } lane_flags_t;

  function automatic int num_width(int frac);
    int pw;
    int nx;
    int nz;
    pw = SCALE_W + COORD_WIDTH;
    nx = pw + DIM_W + 1;
    nz = ((pw > SCALE_W + frac) ? pw : SCALE_W + frac) + 1 + DEPTH_SHIFT;
    return (nx > nz) ? nx : nz;
  endfunction

  function automatic int quo_width(int frac);
    return frac + QUO_GUARD;
  endfunction

endpackage

@@ rtl/ppp_front.sv @@
module ppp_front #(
  parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF,
  localparam int CW = ppp_pkg::COORD_WIDTH,
  localparam int NW = ppp_pkg::num_width(FRAC_BITS),
  localparam int QW = ppp_pkg::quo_width(FRAC_BITS),
  localparam int PW = ppp_pkg::SCALE_W + ppp_pkg::COORD_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ppp_pkg::cfg_t                        cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ppp_pkg::point_t                      point,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ppp_pkg::LANES-1:0][NW-1:0]    mag,
  output logic [CW-1:0]                        w,
  output ppp_pkg::lane_flags_t                 flags
);

  logic v1, v2, v3;
  logic e1, e2, e3;

  logic signed [PW-1:0] p_x, p_y, p_z;
  logic [CW-1:0] w1, w2;
  logic behind1, behind2;

  logic [ppp_pkg::LANES-1:0][NW-1:0] n;
  logic signed [NW-1:0] zo_ext;
  logic signed [NW-1:0] zsum;
  logic signed [NW-1:0] nz_next;
  logic [ppp_pkg::LANES-1:0][NW-1:0] mag_next;
  logic [ppp_pkg::LANES-1:0] ovf_next;

  assign e3 = !v3 || out_ready;
  assign e2 = !v2 || e3;
  assign e1 = !v1 || e2;
  assign in_ready  = e1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (e1) v1 <= in_valid;
      if (e2) v2 <= v1;
      if (e3) v3 <= v2;
    end
  end

  // stage 1: coefficient times coordinate
  always_ff @(posedge clk) begin
    if (e1) begin
      p_x     <= $signed(cfg.x_scale) * $signed(point.point_x);
      p_y     <= $signed(cfg.y_scale) * $signed(point.point_y);
      p_z     <= $signed(cfg.z_scale) * $signed(point.point_z);
      w1      <= -point.point_z;
      behind1 <= !point.point_z[CW-1];
    end
  end

  // stage 2: scale by viewport size, depth offset and shift
  always_comb begin
    zo_ext  = NW'($signed(cfg.z_offset));
    zsum    = NW'(p_z) + (zo_ext <<< FRAC_BITS);
    nz_next = zsum <<< ppp_pkg::DEPTH_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (e2) begin
      n[0]    <= p_x * $signed({1'b0, cfg.screen_width});
      n[1]    <= p_y * $signed({1'b0, cfg.screen_height});
      n[2]    <= nz_next;
      w2      <= w1;
      behind2 <= behind1;
    end
  end

  // stage 3: sign and magnitude, quotient range check
  always_comb begin
    for (int l = 0; l < ppp_pkg::LANES; l++) begin
      mag_next[l] = n[l][NW-1] ? (~n[l] + 1'b1) : n[l];
      ovf_next[l] = mag_next[l][NW-1:QW] >= (NW-QW)'(w2);
    end
  end

  always_ff @(posedge clk) begin
    if (e3) begin
      mag          <= mag_next;
      w            <= w2;
      flags.ovf    <= ovf_next;
      flags.behind <= behind2;
      for (int l = 0; l < ppp_pkg::LANES; l++) flags.neg[l] <= n[l][NW-1];
    end
  end

endmodule

@@ rtl/ppp_div.sv @@
module ppp_div #(
  parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF,
  localparam int CW = ppp_pkg::COORD_WIDTH,
  localparam int NW = ppp_pkg::num_width(FRAC_BITS),
  localparam int QW = ppp_pkg::quo_width(FRAC_BITS)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ppp_pkg::LANES-1:0][NW-1:0]    mag,
  input  logic [CW-1:0]                        w,
  input  ppp_pkg::lane_flags_t                 in_flags,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ppp_pkg::LANES-1:0][QW-1:0]    quo,
  output logic [ppp_pkg::LANES-1:0]            rem_nz,
  output ppp_pkg::lane_flags_t                 flags
);

  // one quotient bit per stage, restoring
  logic v [QW+1];
  logic [QW+1:1] adv;
  logic [ppp_pkg::LANES-1:0][CW-1:0] rem [QW+1];
  logic [ppp_pkg::LANES-1:0][QW-1:0] low [QW+1];
  logic [ppp_pkg::LANES-1:0][QW-1:0] q [QW+1];
  logic [CW-1:0] wd [QW+1];
  ppp_pkg::lane_flags_t fl [QW+1];

  assign v[0]  = in_valid;
  assign wd[0] = w;
  assign fl[0] = in_flags;
  always_comb begin
    for (int l = 0; l < ppp_pkg::LANES; l++) begin
      rem[0][l] = mag[l][QW +: CW];
      low[0][l] = mag[l][QW-1:0];
      q[0][l]   = '0;
    end
  end

  assign adv[QW+1] = out_ready;
  assign in_ready  = adv[1];

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [ppp_pkg::LANES-1:0][CW:0]    trial;
    logic [ppp_pkg::LANES-1:0]          fits;
    logic [ppp_pkg::LANES-1:0][CW-1:0]  rem_next;

    assign adv[k] = !v[k] || adv[k+1];

    always_comb begin
      for (int l = 0; l < ppp_pkg::LANES; l++) begin
        trial[l]    = {rem[k-1][l], low[k-1][l][QW-1]};
        fits[l]     = trial[l] >= {1'b0, wd[k-1]};
        rem_next[l] = fits[l] ? CW'(trial[l] - {1'b0, wd[k-1]}) : trial[l][CW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        wd[k] <= wd[k-1];
        fl[k] <= fl[k-1];
        for (int l = 0; l < ppp_pkg::LANES; l++) begin
          rem[k][l] <= rem_next[l];
          low[k][l] <= {low[k-1][l][QW-2:0], 1'b0};
          q[k][l]   <= {q[k-1][l][QW-2:0], fits[l]};
        end
      end
    end
  end

  assign out_valid = v[QW];
  assign flags     = fl[QW];
  always_comb begin
    for (int l = 0; l < ppp_pkg::LANES; l++) begin
      quo[l]    = q[QW][l];
      rem_nz[l] = |rem[QW][l];
    end
  end

endmodule

@@ rtl/ppp_map.sv @@
module ppp_map #(
  parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF,
  localparam int QW = ppp_pkg::quo_width(FRAC_BITS),
  localparam int TW = QW + 2,
  localparam int SW = TW + 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ppp_pkg::cfg_t                        cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ppp_pkg::LANES-1:0][QW-1:0]    quo,
  input  logic [ppp_pkg::LANES-1:0]            rem_nz,
  input  ppp_pkg::lane_flags_t                 flags,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ppp_pkg::result_t                     result
);

  localparam int OUT_MAX  = (1 << (ppp_pkg::OUT_W - 1)) - 1;
  localparam int OUT_MIN  = -(1 << (ppp_pkg::OUT_W - 1));
  localparam int DEP_MAX  = (1 << ppp_pkg::OUT_W) - 1;
  localparam int DEP_HALF = 1 << (ppp_pkg::OUT_W - 1);

  logic v1, v2, e1, e2;
  logic [ppp_pkg::LANES-1:0][TW-1:0] t, t_next, qx, up;
  logic behind1;

  logic signed [SW-1:0] tx, ty, tz, sx, sy, dp;
  logic [SW-1:0] wsh, hsh;
  ppp_pkg::result_t res_next;

  assign e2 = !v2 || out_ready;
  assign e1 = !v1 || e2;
  assign in_ready  = e1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (e1) v1 <= in_valid;
      if (e2) v2 <= v1;
    end
  end

  // signed quotient: lane 0 rounds up (x is mirrored), the others round down
  always_comb begin
    for (int l = 0; l < ppp_pkg::LANES; l++) begin
      qx[l] = TW'(quo[l]);
      up[l] = qx[l] + TW'(rem_nz[l]);
      if (flags.ovf[l]) begin
        t_next[l] = flags.neg[l] ? -(TW'(1) << QW) : (TW'(1) << QW);
      end else if (l == 0) begin
        t_next[l] = flags.neg[l] ? -qx[l] : up[l];
      end else begin
        t_next[l] = flags.neg[l] ? -up[l] : qx[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      t       <= t_next;
      behind1 <= flags.behind;
    end
  end

  always_comb begin
    tx  = $signed(t[0]);
    ty  = $signed(t[1]);
    tz  = $signed(t[2]);
    wsh = SW'(cfg.screen_width) << FRAC_BITS;
    hsh = SW'(cfg.screen_height) << FRAC_BITS;
    sx  = ($signed(wsh) - tx) >>> (FRAC_BITS + 1);
    sy  = ($signed(hsh) + ty) >>> (FRAC_BITS + 1);
    dp  = SW'(DEP_HALF) + (tz >>> FRAC_BITS);

    res_next = '0;
    if (behind1) begin
      res_next.behind_camera = 1'b1;
    end else begin
      if (sx > OUT_MAX) begin
        res_next.screen_x = ppp_pkg::OUT_W'(OUT_MAX);
        res_next.saturated = 1'b1;
      end else if (sx < OUT_MIN) begin
        res_next.screen_x = ppp_pkg::OUT_W'(OUT_MIN);
        res_next.saturated = 1'b1;
      end else begin
        res_next.screen_x = sx[ppp_pkg::OUT_W-1:0];
      end
      if (sy > OUT_MAX) begin
        res_next.screen_y = ppp_pkg::OUT_W'(OUT_MAX);
        res_next.saturated = 1'b1;
      end else if (sy < OUT_MIN) begin
        res_next.screen_y = ppp_pkg::OUT_W'(OUT_MIN);
        res_next.saturated = 1'b1;
      end else begin
        res_next.screen_y = sy[ppp_pkg::OUT_W-1:0];
      end
      if (dp > DEP_MAX) begin
        res_next.depth = ppp_pkg::OUT_W'(DEP_MAX);
        res_next.saturated = 1'b1;
      end else if (dp < 0) begin
        res_next.depth = '0;
        res_next.saturated = 1'b1;
      end else begin
        res_next.depth = dp[ppp_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e2) result <= res_next;
  end

endmodule

@@ rtl/perspective_point_projector.sv @@
// Pipeline from point word to result word: three front stages (two multiplies, then
// sign and range check), one divider stage per quotient bit, two mapping stages.
// Throughput: one point per cycle; every stage stalls on its own, bubbles are squeezed.
// Reset (rst, synchronous): pipeline emptied, registers back to 1.0, 1.0, -1.0, 0,
// 640 and 480. No clearing pass; configuration writes take effect at once.
module perspective_point_projector #(
  parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF,
  localparam int CW = ppp_pkg::COORD_WIDTH,
  localparam int NW = ppp_pkg::num_width(FRAC_BITS),
  localparam int QW = ppp_pkg::quo_width(FRAC_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         point_valid,
  output logic                         point_ready,
  input  ppp_pkg::point_t              point,
  output logic                         result_valid,
  input  logic                         result_ready,
  output ppp_pkg::result_t             result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [ppp_pkg::SCALE_W-1:0]  cfg_data
);

  ppp_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_scale       <= ppp_pkg::X_SCALE_RST;
      cfg.y_scale       <= ppp_pkg::Y_SCALE_RST;
      cfg.z_scale       <= ppp_pkg::Z_SCALE_RST;
      cfg.z_offset      <= ppp_pkg::Z_OFFSET_RST;
      cfg.screen_width  <= ppp_pkg::WIDTH_RST;
      cfg.screen_height <= ppp_pkg::HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ppp_pkg::cfg_reg_t'(cfg_index))
        ppp_pkg::REG_X_SCALE:       cfg.x_scale       <= cfg_data;
        ppp_pkg::REG_Y_SCALE:       cfg.y_scale       <= cfg_data;
        ppp_pkg::REG_Z_SCALE:       cfg.z_scale       <= cfg_data;
        ppp_pkg::REG_Z_OFFSET:      cfg.z_offset      <= cfg_data;
        ppp_pkg::REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[ppp_pkg::DIM_W-1:0];
        ppp_pkg::REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[ppp_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic front_valid, front_ready;
  logic [ppp_pkg::LANES-1:0][NW-1:0] mag;
  logic [CW-1:0] w;
  ppp_pkg::lane_flags_t front_flags;

  logic div_valid, div_ready;
  logic [ppp_pkg::LANES-1:0][QW-1:0] quo;
  logic [ppp_pkg::LANES-1:0] rem_nz;
  ppp_pkg::lane_flags_t div_flags;

  ppp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (point_valid),
    .in_ready  (point_ready),
    .point     (point),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .mag       (mag),
    .w         (w),
    .flags     (front_flags)
  );

  ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .mag       (mag),
    .w         (w),
    .in_flags  (front_flags),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .quo       (quo),
    .rem_nz    (rem_nz),
    .flags     (div_flags)
  );

  ppp_map #(.FRAC_BITS(FRAC_BITS)) u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .quo       (quo),
    .rem_nz    (rem_nz),
    .flags     (div_flags),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .result    (result)
  );

  // input can only be held off by a full pipe behind a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !point_ready |-> (result_valid && !result_ready))
    else $error("input stalled without a stalled result");

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.behind_camera) |->
      (result.screen_x == 0 && result.screen_y == 0 && result.depth == 0 &&
       !result.saturated))
    else $error("behind-camera word carries nonzero fields");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.saturated) |->
      (result.screen_x == 16'sh7fff || result.screen_x == 16'sh8000 ||
       result.screen_y == 16'sh7fff || result.screen_y == 16'sh8000 ||
       result.depth == 16'h0000 || result.depth == 16'hffff))
    else $error("saturated flag without a clamped field");

endmodule

@@ test/tb_perspective_point_projector.sv @@
`timescale 1ns / 100ps

module tb_perspective_point_projector;
  import ppp_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int PIPE_LAT = FRAC + 22;
  localparam int IDLE_LIMIT = 20000;
  localparam logic signed [127:0] ONE = 128'sd1 <<< FRAC;
  localparam logic signed [127:0] QUO_MAX = 128'sd1 <<< 62;

  logic clk;
  logic rst;
  logic point_valid;
  logic point_ready;
  point_t point;
  logic result_valid;
  logic result_ready;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [SCALE_W-1:0] cfg_data;

  perspective_point_projector dut (
    .clk(clk),
    .rst(rst),
    .point_valid(point_valid),
    .point_ready(point_ready),
    .point(point),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow copy of the projection registers
  logic signed [SCALE_W-1:0] sh_x_scale, sh_y_scale, sh_z_scale, sh_z_offset;
  logic [DIM_W-1:0] sh_width, sh_height;

  point_t pending_points[$];
  result_t expected_results[$];
  int errors;
  int points_sent;
  int results_seen;
  int behind_seen;
  int sat_seen;
  int idle_cycles;
  logic point_took;
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // floor(n/d) for d > 0, held to +-2^62
  function automatic logic signed [127:0] floor_quo(logic signed [127:0] n,
                                                    logic signed [127:0] d);
    logic signed [127:0] q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    if (q > QUO_MAX) q = QUO_MAX;
    if (q < -QUO_MAX) q = -QUO_MAX;
    return q;
  endfunction

  function automatic result_t project_point(point_t p);
    logic signed [127:0] px, py, pz, w, xs, ys, zs, zo, wd, ht, n, t, sx, sy, dp;
    result_t r;
    px = p.point_x;
    py = p.point_y;
    pz = p.point_z;
    xs = sh_x_scale;
    ys = sh_y_scale;
    zs = sh_z_scale;
    zo = sh_z_offset;
    wd = {115'd0, sh_width};
    ht = {115'd0, sh_height};
    w = -pz;
    r = '0;
    if (w <= 0) begin
      r.behind_camera = 1'b1;
      return r;
    end
    n = xs * wd * px;
    t = -floor_quo(-n, w);
    sx = (wd * ONE - t) >>> (FRAC + 1);
    n = ys * ht * py;
    t = floor_quo(n, w);
    sy = (ht * ONE + t) >>> (FRAC + 1);
    n = zs * pz + zo * ONE;
    t = floor_quo(n <<< 15, w);
    dp = 32768 + (t >>> FRAC);
    if (sx < -32768) begin sx = -32768; r.saturated = 1'b1; end
    if (sx > 32767) begin sx = 32767; r.saturated = 1'b1; end
    if (sy < -32768) begin sy = -32768; r.saturated = 1'b1; end
    if (sy > 32767) begin sy = 32767; r.saturated = 1'b1; end
    if (dp < 0) begin dp = 0; r.saturated = 1'b1; end
    if (dp > 65535) begin dp = 65535; r.saturated = 1'b1; end
    r.screen_x = sx[15:0];
    r.screen_y = sy[15:0];
    r.depth = dp[15:0];
    return r;
  endfunction

  // sender: bursts with random gaps
  always @(negedge clk) begin
    logic nv;
    point_t np;
    nv = point_valid;
    np = point;
    if (rst) begin
      nv = 1'b0;
    end else if (!point_valid || point_took) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_points.size() > 0) begin
        np = pending_points.pop_front();
        nv = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    point_valid <= nv;
    point <= np;
  end

  // receiver: random stall pattern, one of four modes, redrawn when stall_count wraps
  always @(negedge clk) begin
    stall_count++;
    if (stall_count >= 64) begin
      stall_count = 0;
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= ($urandom_range(0, 1) == 1);
      2: result_ready <= ($urandom_range(0, 3) == 0);
      default: result_ready <= (stall_count % 8) < 5;
    endcase
  end

  always @(posedge clk) begin
    result_t exp_r;
    point_took <= !rst && point_valid && point_ready;
    if (!rst) begin
      if (point_valid && point_ready) begin
        expected_results.push_back(project_point(point));
        points_sent++;
      end
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.behind_camera) behind_seen++;
          if (exp_r.saturated) sat_seen++;
          if (result.screen_x !== exp_r.screen_x) begin
            $error("screen_x exp %0d got %0d", exp_r.screen_x, result.screen_x);
            errors++;
          end
          if (result.screen_y !== exp_r.screen_y) begin
            $error("screen_y exp %0d got %0d", exp_r.screen_y, result.screen_y);
            errors++;
          end
          if (result.depth !== exp_r.depth) begin
            $error("depth exp %0d got %0d", exp_r.depth, result.depth);
            errors++;
          end
          if (result.behind_camera !== exp_r.behind_camera) begin
            $error("behind_camera exp %0b got %0b", exp_r.behind_camera,
                   result.behind_camera);
            errors++;
          end
          if (result.saturated !== exp_r.saturated) begin
            $error("saturated exp %0b got %0b", exp_r.saturated, result.saturated);
            errors++;
          end
        end
      end
      if ((point_valid && point_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake in %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [SCALE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_X_SCALE: sh_x_scale = data;
      REG_Y_SCALE: sh_y_scale = data;
      REG_Z_SCALE: sh_z_scale = data;
      REG_Z_OFFSET: sh_z_offset = data;
      REG_SCREEN_WIDTH: sh_width = data[DIM_W-1:0];
      REG_SCREEN_HEIGHT: sh_height = data[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] xs, logic [31:0] ys, logic [31:0] zs,
                           logic [31:0] zo, logic [31:0] wd, logic [31:0] ht);
    write_reg(REG_X_SCALE, xs);
    write_reg(REG_Y_SCALE, ys);
    write_reg(REG_Z_SCALE, zs);
    write_reg(REG_Z_OFFSET, zo);
    write_reg(REG_SCREEN_WIDTH, wd);
    write_reg(REG_SCREEN_HEIGHT, ht);
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    pending_points.push_back(p);
  endtask

  task automatic drain;
    wait (pending_points.size() == 0 && expected_results.size() == 0 && !point_valid);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // mostly points in front with |x|,|y| near |z|; some raw noise and behind points
  task automatic add_random(int count);
    int k;
    logic [31:0] z, x, y;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1: add_point($urandom, $urandom, $urandom);
        2: add_point($urandom, $urandom, $urandom_range(0, 32'h7fffffff));
        3: add_point($urandom, $urandom, 32'h80000000 | $urandom_range(0, 255));
        default: begin
          z = -$urandom_range(1, 32'h00640000);
          x = $signed($urandom_range(0, 2 * (-z))) + z;
          y = $signed($urandom_range(0, 2 * (-z))) + z;
          add_point(x, y, z);
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    point_valid = 1'b0;
    point = '0;
    result_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_X_SCALE;
    cfg_data = '0;
    errors = 0;
    points_sent = 0;
    results_seen = 0;
    behind_seen = 0;
    sat_seen = 0;
    idle_cycles = 0;
    burst_left = 8;
    gap_left = 0;
    stall_mode = 0;
    stall_count = 0;
    sh_x_scale = X_SCALE_RST;
    sh_y_scale = Y_SCALE_RST;
    sh_z_scale = Z_SCALE_RST;
    sh_z_offset = Z_OFFSET_RST;
    sh_width = WIDTH_RST;
    sh_height = HEIGHT_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset registers
    add_point(32'h0, 32'h0, 32'h0);                  // w zero
    add_point(32'h0001_0000, 32'h0, 32'h0000_0001);  // behind
    add_point(32'h0, 32'h0, 32'h7fff_ffff);
    add_point(32'h0, 32'h0, 32'hffff_ffff);          // smallest w, huge quotients
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    add_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    add_point(32'h0, 32'h0, 32'hffff_0000);          // ndc zero
    add_point(32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
    add_point(32'hffff_0000, 32'hffff_0000, 32'hffff_0000);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000);
    add_point(32'h0000_8000, 32'hffff_8000, 32'hfffe_0000);
    add_point(32'h0003_0000, 32'hfffd_0000, 32'hfffe_0000);  // off screen
    add_point(32'h5555_5555, 32'haaaa_aaaa, 32'hc000_0001);
    add_random(250);
    drain();

    // extremes of every register
    write_all(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h1fff, 32'h0);
    add_point(32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    add_random(200);
    drain();

    write_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h0, 32'h1fff);
    add_random(150);
    drain();

    // typical camera
    write_all(32'h0001_8000, 32'h0002_0000, 32'hfffe_ff7d, 32'hffff_cccd,
              32'd1920, 32'd1080);
    add_random(250);
    drain();

    write_all($urandom, $urandom, $urandom, $urandom, 32'd1, 32'd1);
    add_random(200);
    drain();

    write_all(32'h0000_4000, 32'h0000_c000, 32'hffff_0000 - $urandom_range(0, 4096),
              -$urandom_range(0, 32'h0004_0000), 32'd4096, 32'd4096);
    add_random(250);
    drain();

    $display("%0d points sent, %0d results checked (%0d behind camera, %0d clamped)",
             points_sent, results_seen, behind_seen, sat_seen);
    $display("six register settings incl. extremes, bursty sender, varied receiver stalls");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (expected_results.size() != 0)
        $error("%0d results never arrived", expected_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ppp_pkg.sv
rtl/ppp_front.sv
rtl/ppp_div.sv
rtl/ppp_map.sv
rtl/perspective_point_projector.sv
test/tb_perspective_point_projector.sv
